// ===== hdl/assert_macros.svh =====
// assertion macros used by obm_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define OBM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define OBM_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define OBM_ASSERT(lbl, clk, rst_n, prop)
`define OBM_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hdl/obm_pkg.sv =====
// types, constants and the crc function of the 1-wire bus master
package obm_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgAddrW-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_RESET_TAIL    = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_WRITE_ONE     = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_WRITE_ZERO    = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_RECOVERY      = 3'd5;
  localparam logic [CfgAddrW-1:0] CFG_READ_LOW      = 3'd6;
  localparam logic [CfgAddrW-1:0] CFG_READ_SAMPLE   = 3'd7;

  localparam logic [9:0] RstResetLow     = 10'd500;
  localparam logic [7:0] RstPresenceWait = 8'd65;
  localparam logic [9:0] RstResetTail    = 10'd456;
  localparam logic [7:0] RstWriteOne     = 8'd11;
  localparam logic [7:0] RstWriteZero    = 8'd70;
  localparam logic [7:0] RstRecovery     = 8'd60;
  localparam logic [7:0] RstReadLow      = 8'd1;
  localparam logic [7:0] RstReadSample   = 8'd14;

  // reflected x^8+x^5+x^4+1
  localparam logic [7:0] CrcPoly = 8'h8C;
  localparam logic [2:0] LastBit = 3'd7;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_REC   = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_REC   = 4'd8
  } phase_e;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] presence_sample_time;
    logic [9:0] reset_tail_time;
    logic [7:0] write_one_low_time;
    logic [7:0] write_zero_low_time;
    logic [7:0] slot_recovery_time;
    logic [7:0] read_low_time;
    logic [7:0] read_sample_delay;
  } cfg_t;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] data_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [1:0] presence_status;
    logic [7:0] crc_value;
    logic       command_rejected;
  } result_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/obm_chan_if.sv =====
// valid/ready channel carrying one beat of payload
interface obm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/obm_engine.sv =====
// bus timing state machine, bit shifter and crc, one tick per accepted beat
`include "assert_macros.svh"

module obm_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  obm_pkg::cfg_t    cfg_i,
  input  obm_pkg::item_t   item_i,
  output obm_pkg::result_t res_o
);

  obm_pkg::phase_e phase_q, phase_d, phase_a;
  logic [9:0] timer_q, timer_d, timer_a;
  logic [2:0] bit_q, bit_d, bit_a;
  logic [7:0] shift_q, shift_d, shift_a;
  logic [1:0] lsc_q, lsc_d, lsc_a;
  logic [7:0] crc_q, crc_d, crc_a;
  logic [7:0] lrb_q, lrb_d;
  logic [9:0] len;
  logic [10:0] tick;
  logic [7:0] rd_byte;
  logic rejected, done, drive, low_seen;

  // command start
  always_comb begin
    phase_a = phase_q;
    timer_a = timer_q;
    bit_a = bit_q;
    shift_a = shift_q;
    lsc_a = lsc_q;
    crc_a = crc_q;
    rejected = 1'b0;
    if (phase_q != obm_pkg::PH_IDLE) begin
      rejected = (item_i.opcode != obm_pkg::OP_IDLE);
    end else begin
      unique case (item_i.opcode)
        obm_pkg::OP_RESET: begin
          phase_a = obm_pkg::PH_RST_LOW;
          lsc_a = '0;
          crc_a = '0;
        end
        obm_pkg::OP_WRITE: begin
          phase_a = obm_pkg::PH_WR_LOW;
          shift_a = item_i.data_byte;
        end
        obm_pkg::OP_READ: begin
          phase_a = obm_pkg::PH_RD_LOW;
          shift_a = '0;
        end
        obm_pkg::OP_IDLE: begin
          phase_a = obm_pkg::PH_IDLE;
        end
      endcase
      if (item_i.opcode != obm_pkg::OP_IDLE) begin
        timer_a = '0;
        bit_a = '0;
      end
    end
  end

  // phase duration
  always_comb begin
    unique case (phase_a)
      obm_pkg::PH_RST_LOW:  len = cfg_i.reset_low_time;
      obm_pkg::PH_RST_WAIT: len = {2'b00, cfg_i.presence_sample_time};
      obm_pkg::PH_RST_TAIL: len = cfg_i.reset_tail_time;
      obm_pkg::PH_WR_LOW:   len = shift_a[0] ? {2'b00, cfg_i.write_one_low_time}
                                             : {2'b00, cfg_i.write_zero_low_time};
      obm_pkg::PH_RD_LOW:   len = {2'b00, cfg_i.read_low_time};
      obm_pkg::PH_RD_WAIT:  len = {2'b00, cfg_i.read_sample_delay};
      default:              len = {2'b00, cfg_i.slot_recovery_time};
    endcase
  end

  assign tick = {1'b0, timer_a} + 11'd1;
  assign low_seen = !item_i.line_level && (lsc_a != 2'd2);
  assign rd_byte = (phase_a == obm_pkg::PH_RD_WAIT) ? {item_i.line_level, shift_a[7:1]}
                                                     : shift_a;

  // phase advance
  always_comb begin
    phase_d = phase_a;
    timer_d = timer_a;
    bit_d = bit_a;
    shift_d = shift_a;
    lsc_d = lsc_a;
    crc_d = crc_a;
    lrb_d = lrb_q;
    done = 1'b0;
    drive = (phase_a == obm_pkg::PH_RST_LOW) || (phase_a == obm_pkg::PH_WR_LOW) ||
            (phase_a == obm_pkg::PH_RD_LOW);
    if (phase_a != obm_pkg::PH_IDLE) begin
      if (tick < {1'b0, len}) begin
        timer_d = tick[9:0];
      end else begin
        timer_d = '0;
        unique case (phase_a)
          obm_pkg::PH_RST_LOW: begin
            phase_d = obm_pkg::PH_RST_WAIT;
          end
          obm_pkg::PH_RST_WAIT: begin
            if (low_seen) lsc_d = lsc_a + 2'd1;
            phase_d = obm_pkg::PH_RST_TAIL;
          end
          obm_pkg::PH_RST_TAIL: begin
            if (low_seen) lsc_d = lsc_a + 2'd1;
            phase_d = obm_pkg::PH_IDLE;
            done = 1'b1;
          end
          obm_pkg::PH_WR_LOW, obm_pkg::PH_WR_REC: begin
            if ((phase_a == obm_pkg::PH_WR_LOW) && shift_a[0] &&
                (cfg_i.slot_recovery_time != '0)) begin
              phase_d = obm_pkg::PH_WR_REC;
            end else begin
              shift_d = shift_a >> 1;
              if (bit_a == obm_pkg::LastBit) begin
                phase_d = obm_pkg::PH_IDLE;
                done = 1'b1;
              end else begin
                bit_d = bit_a + 3'd1;
                phase_d = obm_pkg::PH_WR_LOW;
              end
            end
          end
          obm_pkg::PH_RD_LOW: begin
            phase_d = obm_pkg::PH_RD_WAIT;
          end
          obm_pkg::PH_RD_WAIT, obm_pkg::PH_RD_REC: begin
            shift_d = rd_byte;
            if ((phase_a == obm_pkg::PH_RD_WAIT) && (cfg_i.slot_recovery_time != '0)) begin
              phase_d = obm_pkg::PH_RD_REC;
            end else if (bit_a == obm_pkg::LastBit) begin
              lrb_d = rd_byte;
              crc_d = obm_pkg::crc8_byte(crc_a, rd_byte);
              phase_d = obm_pkg::PH_IDLE;
              done = 1'b1;
            end else begin
              bit_d = bit_a + 3'd1;
              phase_d = obm_pkg::PH_RD_LOW;
            end
          end
          default: begin
            phase_d = obm_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_o.drive_low = drive;
    res_o.busy_res = (phase_d != obm_pkg::PH_IDLE);
    res_o.done_res = done;
    res_o.read_data = lrb_d;
    res_o.presence_status = lsc_d;
    res_o.crc_value = crc_d;
    res_o.command_rejected = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= obm_pkg::PH_IDLE;
      timer_q <= '0;
      bit_q <= '0;
      shift_q <= '0;
      lsc_q <= '0;
      crc_q <= '0;
      lrb_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      bit_q <= bit_d;
      shift_q <= shift_d;
      lsc_q <= lsc_d;
      crc_q <= crc_d;
      lrb_q <= lrb_d;
    end
  end

  `OBM_ASSERT(a_done_goes_idle, clk_i, rst_ni, step_i && done |=> phase_q == obm_pkg::PH_IDLE)
  `OBM_ASSERT(a_reject_only_busy, clk_i, rst_ni, rejected |-> phase_q != obm_pkg::PH_IDLE)
  `OBM_ASSERT(a_idle_timer_clear, clk_i, rst_ni, phase_q == obm_pkg::PH_IDLE |-> timer_q == '0)
  `OBM_ASSERT_NEVER(a_presence_sat, clk_i, rst_ni, lsc_q == 2'd3)

endmodule

// ===== hdl/onewire_bus_master.sv =====
// 1-wire bus master top level: configuration registers and result register
// an accepted tick beat's result is registered and offered in the next cycle
// one tick beat per cycle when not stalled; each advances the bus state machine
// input ready drops only while the result register is full and not taken
// rst_ni clears the state machine, crc, presence count, result valid and
// loads the default timing values

module onewire_bus_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [obm_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [obm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  obm_chan_if.sink                      in_i,
  obm_chan_if.source                    out_o
);

  obm_pkg::cfg_t    cfg_q;
  obm_pkg::item_t   item;
  obm_pkg::result_t res;
  obm_pkg::result_t out_data_q;
  logic             out_valid_q;
  logic             step;

  assign item = in_i.data;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step = in_i.valid && in_i.ready;

  obm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg_q),
    .item_i (item),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time <= obm_pkg::RstResetLow;
      cfg_q.presence_sample_time <= obm_pkg::RstPresenceWait;
      cfg_q.reset_tail_time <= obm_pkg::RstResetTail;
      cfg_q.write_one_low_time <= obm_pkg::RstWriteOne;
      cfg_q.write_zero_low_time <= obm_pkg::RstWriteZero;
      cfg_q.slot_recovery_time <= obm_pkg::RstRecovery;
      cfg_q.read_low_time <= obm_pkg::RstReadLow;
      cfg_q.read_sample_delay <= obm_pkg::RstReadSample;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        obm_pkg::CFG_RESET_LOW:     cfg_q.reset_low_time <= cfg_wdata_i;
        obm_pkg::CFG_PRESENCE_WAIT: cfg_q.presence_sample_time <= cfg_wdata_i[7:0];
        obm_pkg::CFG_RESET_TAIL:    cfg_q.reset_tail_time <= cfg_wdata_i;
        obm_pkg::CFG_WRITE_ONE:     cfg_q.write_one_low_time <= cfg_wdata_i[7:0];
        obm_pkg::CFG_WRITE_ZERO:    cfg_q.write_zero_low_time <= cfg_wdata_i[7:0];
        obm_pkg::CFG_RECOVERY:      cfg_q.slot_recovery_time <= cfg_wdata_i[7:0];
        obm_pkg::CFG_READ_LOW:      cfg_q.read_low_time <= cfg_wdata_i[7:0];
        obm_pkg::CFG_READ_SAMPLE:   cfg_q.read_sample_delay <= cfg_wdata_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data = out_data_q;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the 1-wire bus master: tick stream, bus device and checker
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [obm_pkg::CfgAddrW-1:0] cfg_addr_i;
  logic [obm_pkg::CfgDataW-1:0] cfg_wdata_i;

  obm_chan_if #(.payload_t(obm_pkg::item_t)) in_if ();
  obm_chan_if #(.payload_t(obm_pkg::result_t)) out_if ();

  onewire_bus_master u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #10ns clk_i = ~clk_i;

  // bus master state as predicted
  obm_pkg::cfg_t   tcfg = '{obm_pkg::RstResetLow, obm_pkg::RstPresenceWait,
                            obm_pkg::RstResetTail, obm_pkg::RstWriteOne,
                            obm_pkg::RstWriteZero, obm_pkg::RstRecovery,
                            obm_pkg::RstReadLow, obm_pkg::RstReadSample};
  obm_pkg::phase_e ph = obm_pkg::PH_IDLE;
  logic [9:0] ph_timer = '0;
  logic [2:0] bit_pos = '0;
  logic [7:0] shreg = '0;
  logic [1:0] low_cnt = '0;
  logic [7:0] crc_acc = '0;
  logic [7:0] last_rd = '0;

  obm_pkg::result_t due_results[$];
  int unsigned errors = 0;
  int unsigned items_done = 0;

  // emulated bus device
  logic       dev_present = 1'b1;
  logic       dev_short = 1'b0;
  logic [7:0] dev_byte = '0;
  logic [7:0] dev_reply[$];
  int unsigned noise_pct = 0;
  int unsigned reject_pct = 0;

  logic src_gaps = 1'b1;
  logic sink_gaps = 1'b1;
  int unsigned holds_asked = 0;
  int unsigned holds_taken = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ b[i]) ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic close_write_slot();
    shreg = shreg >> 1;
    if (bit_pos == obm_pkg::LastBit) return 1'b1;
    bit_pos++;
    ph = obm_pkg::PH_WR_LOW;
    return 1'b0;
  endfunction

  function automatic logic close_read_slot();
    if (bit_pos == obm_pkg::LastBit) begin
      last_rd = shreg;
      crc_acc = crc_next(crc_acc, shreg);
      return 1'b1;
    end
    bit_pos++;
    ph = obm_pkg::PH_RD_LOW;
    return 1'b0;
  endfunction

  // advances the predicted master by one tick and returns the result beat
  function automatic obm_pkg::result_t bus_step(obm_pkg::item_t it);
    obm_pkg::result_t r;
    logic fin, rej, drv;
    logic [9:0] len;
    logic [10:0] t;
    fin = 1'b0;
    rej = 1'b0;
    drv = 1'b0;
    if (ph != obm_pkg::PH_IDLE) begin
      if (it.opcode != obm_pkg::OP_IDLE) rej = 1'b1;
    end else if (it.opcode != obm_pkg::OP_IDLE) begin
      ph_timer = '0;
      bit_pos = '0;
      case (it.opcode)
        obm_pkg::OP_RESET: begin
          ph = obm_pkg::PH_RST_LOW;
          low_cnt = '0;
          crc_acc = '0;
        end
        obm_pkg::OP_WRITE: begin
          ph = obm_pkg::PH_WR_LOW;
          shreg = it.data_byte;
        end
        default: begin
          ph = obm_pkg::PH_RD_LOW;
          shreg = '0;
        end
      endcase
    end
    if (ph != obm_pkg::PH_IDLE) begin
      drv = (ph == obm_pkg::PH_RST_LOW) || (ph == obm_pkg::PH_WR_LOW) ||
            (ph == obm_pkg::PH_RD_LOW);
      case (ph)
        obm_pkg::PH_RST_LOW:  len = tcfg.reset_low_time;
        obm_pkg::PH_RST_WAIT: len = {2'b00, tcfg.presence_sample_time};
        obm_pkg::PH_RST_TAIL: len = tcfg.reset_tail_time;
        obm_pkg::PH_WR_LOW:   len = shreg[0] ? {2'b00, tcfg.write_one_low_time}
                                             : {2'b00, tcfg.write_zero_low_time};
        obm_pkg::PH_RD_LOW:   len = {2'b00, tcfg.read_low_time};
        obm_pkg::PH_RD_WAIT:  len = {2'b00, tcfg.read_sample_delay};
        default:              len = {2'b00, tcfg.slot_recovery_time};
      endcase
      t = {1'b0, ph_timer} + 11'd1;
      if (t < {1'b0, len}) begin
        ph_timer = t[9:0];
      end else begin
        ph_timer = '0;
        case (ph)
          obm_pkg::PH_RST_LOW: ph = obm_pkg::PH_RST_WAIT;
          obm_pkg::PH_RST_WAIT: begin
            if (!it.line_level && low_cnt < 2'd2) low_cnt = low_cnt + 2'd1;
            ph = obm_pkg::PH_RST_TAIL;
          end
          obm_pkg::PH_RST_TAIL: begin
            if (!it.line_level && low_cnt < 2'd2) low_cnt = low_cnt + 2'd1;
            fin = 1'b1;
          end
          obm_pkg::PH_WR_LOW: begin
            if (shreg[0] && tcfg.slot_recovery_time != '0) ph = obm_pkg::PH_WR_REC;
            else fin = close_write_slot();
          end
          obm_pkg::PH_WR_REC: fin = close_write_slot();
          obm_pkg::PH_RD_LOW: ph = obm_pkg::PH_RD_WAIT;
          obm_pkg::PH_RD_WAIT: begin
            shreg = {it.line_level, shreg[7:1]};
            if (tcfg.slot_recovery_time != '0) ph = obm_pkg::PH_RD_REC;
            else fin = close_read_slot();
          end
          obm_pkg::PH_RD_REC: fin = close_read_slot();
          default: ph = obm_pkg::PH_IDLE;
        endcase
        if (fin) ph = obm_pkg::PH_IDLE;
      end
    end
    r.drive_low = drv;
    r.busy_res = (ph != obm_pkg::PH_IDLE);
    r.done_res = fin;
    r.read_data = last_rd;
    r.presence_status = low_cnt;
    r.crc_value = crc_acc;
    r.command_rejected = rej;
    return r;
  endfunction

  // level the device puts on the bus during the coming tick
  function automatic logic bus_level();
    if ($urandom_range(0, 99) < noise_pct) return 1'($urandom_range(0, 1));
    case (ph)
      obm_pkg::PH_RST_WAIT: return !dev_present;
      obm_pkg::PH_RST_TAIL: return !dev_short;
      obm_pkg::PH_RD_WAIT:  return dev_byte[bit_pos];
      default:              return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic obm_pkg::cfg_t pick_timing(int unsigned top);
    obm_pkg::cfg_t c;
    c.reset_low_time = 10'($urandom_range(0, top));
    c.presence_sample_time = 8'($urandom_range(0, top));
    c.reset_tail_time = 10'($urandom_range(0, top));
    c.write_one_low_time = 8'($urandom_range(0, top));
    c.write_zero_low_time = 8'($urandom_range(0, top));
    c.slot_recovery_time = 8'($urandom_range(0, top));
    c.read_low_time = 8'($urandom_range(0, top));
    c.read_sample_delay = 8'($urandom_range(0, top));
    return c;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    obm_pkg::result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("drive_low", 8'(want.drive_low), 8'(out_if.data.drive_low));
        check_field("busy_res", 8'(want.busy_res), 8'(out_if.data.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_if.data.done_res));
        check_field("read_data", want.read_data, out_if.data.read_data);
        check_field("presence_status", 8'(want.presence_status),
                    8'(out_if.data.presence_status));
        check_field("crc_value", want.crc_value, out_if.data.crc_value);
        check_field("command_rejected", 8'(want.command_rejected),
                    8'(out_if.data.command_rejected));
      end
    end
  end

  // result receiver with random stalls and one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (holds_taken != holds_asked) begin
        holds_taken = holds_asked;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && sink_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_tick(obm_pkg::opcode_e op, logic [7:0] d);
    obm_pkg::item_t it;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    it.opcode = op;
    it.data_byte = d;
    it.line_level = bus_level();
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (ph != obm_pkg::PH_IDLE || op != obm_pkg::OP_IDLE) items_done++;
    due_results.push_back(bus_step(it));
    @(negedge clk_i);
  endtask

  // issues a command on an idle master and ticks until it has finished
  task automatic run_cmd(obm_pkg::opcode_e op, logic [7:0] d);
    obm_pkg::opcode_e stray;
    if (op == obm_pkg::OP_READ) begin
      dev_byte = (dev_reply.size() != 0) ? dev_reply.pop_front() : 8'($urandom);
    end
    send_tick(op, d);
    while (ph != obm_pkg::PH_IDLE) begin
      stray = ($urandom_range(0, 99) < reject_pct)
              ? obm_pkg::opcode_e'(2'($urandom_range(1, 3)))
              : obm_pkg::OP_IDLE;
      send_tick(stray, 8'($urandom));
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [obm_pkg::CfgAddrW-1:0] addr,
                           logic [obm_pkg::CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= value;
    @(negedge clk_i);
  endtask

  task automatic set_timing(obm_pkg::cfg_t c);
    drain();
    write_reg(obm_pkg::CFG_RESET_LOW, c.reset_low_time);
    write_reg(obm_pkg::CFG_PRESENCE_WAIT, 10'(c.presence_sample_time));
    write_reg(obm_pkg::CFG_RESET_TAIL, c.reset_tail_time);
    write_reg(obm_pkg::CFG_WRITE_ONE, 10'(c.write_one_low_time));
    write_reg(obm_pkg::CFG_WRITE_ZERO, 10'(c.write_zero_low_time));
    write_reg(obm_pkg::CFG_RECOVERY, 10'(c.slot_recovery_time));
    write_reg(obm_pkg::CFG_READ_LOW, 10'(c.read_low_time));
    write_reg(obm_pkg::CFG_READ_SAMPLE, 10'(c.read_sample_delay));
    cfg_we_i <= 1'b0;
    tcfg = c;
  endtask

  // reset, a few writes, reads that end in their own crc; or random commands with noise
  task automatic run_transaction();
    logic [7:0] blk[$];
    logic [7:0] c;
    int unsigned k;
    if ($urandom_range(0, 3) != 0) begin
      noise_pct = 0;
      reject_pct = $urandom_range(0, 10);
      dev_present = ($urandom_range(0, 7) != 0);
      dev_short = ($urandom_range(0, 15) == 0);
      run_cmd(obm_pkg::OP_RESET, 8'($urandom));
      repeat ($urandom_range(1, 3)) run_cmd(obm_pkg::OP_WRITE, 8'($urandom));
      k = $urandom_range(2, 5);
      c = '0;
      repeat (k - 1) begin
        blk.push_back(8'($urandom));
        c = crc_next(c, blk[$]);
      end
      blk.push_back(c);
      dev_reply = blk;
      repeat (k) run_cmd(obm_pkg::OP_READ, 8'($urandom));
    end else begin
      noise_pct = 30;
      reject_pct = 40;
      dev_present = 1'($urandom);
      dev_short = 1'($urandom);
      repeat ($urandom_range(1, 6)) begin
        run_cmd(obm_pkg::opcode_e'(2'($urandom)), 8'($urandom));
      end
    end
  endtask

  task automatic test_power_on_timing();
    run_cmd(obm_pkg::OP_IDLE, 8'hFF);
    run_cmd(obm_pkg::OP_RESET, 8'h00);
  endtask

  task automatic test_zero_timing();
    set_timing('0);
    dev_short = 1'b1;
    run_cmd(obm_pkg::OP_RESET, 8'h00);
    reject_pct = 50;
    run_cmd(obm_pkg::OP_WRITE, 8'h00);
    reject_pct = 0;
    dev_reply = '{8'hFF};
    run_cmd(obm_pkg::OP_READ, 8'h00);
    dev_present = 1'b0;
    dev_short = 1'b0;
    run_cmd(obm_pkg::OP_RESET, 8'hFF);
    run_cmd(obm_pkg::OP_WRITE, 8'hFF);
  endtask

  task automatic test_max_timing();
    set_timing('{10'd1, 8'd1, 10'd1, 8'd255, 8'd1, 8'd0, 8'd1, 8'd1});
    dev_present = 1'b1;
    reject_pct = 2;
    run_cmd(obm_pkg::OP_RESET, 8'h00);
    run_cmd(obm_pkg::OP_WRITE, 8'h80);
    dev_reply = '{8'h80};
    run_cmd(obm_pkg::OP_READ, 8'h00);
    reject_pct = 0;
  endtask

  task automatic test_receiver_hold();
    set_timing(pick_timing(2));
    dev_present = 1'b1;
    holds_asked++;
    run_cmd(obm_pkg::OP_RESET, 8'h00);
    run_cmd(obm_pkg::OP_READ, 8'h00);
    run_cmd(obm_pkg::OP_WRITE, 8'($urandom));
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    stop_at = items_done + 200;
    while (items_done < stop_at) begin
      set_timing(pick_timing(($urandom_range(0, 4) == 0) ? 4 : 2));
      src_gaps = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      run_transaction();
    end
  endtask

  task automatic test_steady_stream();
    int unsigned stop_at;
    stop_at = items_done + 100;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    set_timing(pick_timing(3));
    while (items_done < stop_at) run_transaction();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_power_on_timing();
    test_zero_timing();
    test_max_timing();
    test_receiver_hold();
    test_random_traffic();
    test_steady_stream();

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== onewire_bus_master.f =====
+incdir+hdl
hdl/obm_pkg.sv
hdl/obm_chan_if.sv
hdl/obm_engine.sv
hdl/onewire_bus_master.sv
tb/tb_top.sv
